/* sv/udv_pkg.sv */
// Package for the direction vector block: widths, stage counts and the result type.
// Used by the interfaces and every module of the block; depends on nothing.
package udv_pkg;

    localparam int COMPONENT_BITS     = 32;
    localparam int UNIT_FRACTION_BITS = 30;
    localparam int LANES              = 3;

    localparam int DIFF_BITS     = COMPONENT_BITS + 1;
    localparam int ABS_BITS      = COMPONENT_BITS;
    localparam int SQ_BITS       = 2 * ABS_BITS;
    localparam int SUM_BITS      = SQ_BITS + 2;
    localparam int LEN_BITS      = SUM_BITS / 2;
    localparam int LEN_REM_BITS  = LEN_BITS + 2;
    localparam int QUO_BITS      = 2 * UNIT_FRACTION_BITS + 1;
    localparam int QPAD_BITS     = QUO_BITS + 1;
    localparam int ROOT_BITS     = UNIT_FRACTION_BITS + 1;
    localparam int ROOT_REM_BITS = ROOT_BITS + 2;
    localparam int UNIT_BITS     = UNIT_FRACTION_BITS + 2;

    localparam int UNIT_STAGES  = QUO_BITS + ROOT_BITS;
    localparam int LEN_DELAY    = UNIT_STAGES - LEN_BITS;
    localparam int FRONT_STAGES = 3;
    localparam int PIPE_STAGES  = FRONT_STAGES + UNIT_STAGES;

    typedef struct packed {
        logic signed [UNIT_BITS-1:0] unit_x;
        logic signed [UNIT_BITS-1:0] unit_y;
        logic signed [UNIT_BITS-1:0] unit_z;
        logic [LEN_BITS-1:0]         magnitude;
        logic                        zero_length;
    } t_result;

endpackage

/* sv/udv_point_if.sv */
// Input channel of the direction vector block: a start point and an end point.
// Depends on udv_pkg for the component width.
interface udv_point_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [udv_pkg::COMPONENT_BITS-1:0] start_x;
    logic signed [udv_pkg::COMPONENT_BITS-1:0] start_y;
    logic signed [udv_pkg::COMPONENT_BITS-1:0] start_z;
    logic signed [udv_pkg::COMPONENT_BITS-1:0] end_x;
    logic signed [udv_pkg::COMPONENT_BITS-1:0] end_y;
    logic signed [udv_pkg::COMPONENT_BITS-1:0] end_z;

    modport source(output valid, start_x, start_y, start_z, end_x, end_y, end_z, input ready);
    modport sink(input valid, start_x, start_y, start_z, end_x, end_y, end_z, output ready);
endinterface

/* sv/udv_dir_if.sv */
// Output channel of the direction vector block: unit vector, length and zero flag.
// Depends on udv_pkg for the field widths.
interface udv_dir_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [udv_pkg::UNIT_BITS-1:0] unit_x;
    logic signed [udv_pkg::UNIT_BITS-1:0] unit_y;
    logic signed [udv_pkg::UNIT_BITS-1:0] unit_z;
    logic [udv_pkg::LEN_BITS-1:0]         magnitude;
    logic                                  zero_length;

    modport source(output valid, unit_x, unit_y, unit_z, magnitude, zero_length, input ready);
    modport sink(input valid, unit_x, unit_y, unit_z, magnitude, zero_length, output ready);
endinterface

/* sv/unit_direction_vector.sv */
// Top level of the direction vector block: three component lanes, the merge of their
// squares, the length unit and the output register with skid. Depends on udv_pkg and the
// interfaces udv_point_if and udv_dir_if, and instantiates udv_square, udv_unit, udv_length.
//
// A transaction on i_pt carries a start point and an end point, three signed Q16.16
// components each. For each one the block returns one transaction on o_dir: the unit
// vector end minus start in signed Q2.30 truncated toward zero, its length in unsigned
// Q17.16 truncated, and zero_length, set when the two points coincide; then all other
// fields are zero.
// The pipeline holds 95 stages: two per lane for difference and square, one for the sum
// of squares, 61 for the per-lane quotient (one bit a stage) and 31 for its square root
// (one bit a stage). The output register follows the last stage. One transaction enters
// per cycle while i_pt.ready is high, and results leave in order.
// Reset clears every valid bit; no clearing pass is needed.
// When the receiver stalls, the output register holds its result and one more result
// goes to a skid register; only then does the pipeline freeze and i_pt.ready drop.
module unit_direction_vector (
    input  logic       i_clk,
    input  logic       i_rst_n,
    udv_point_if.sink  i_pt,
    udv_dir_if.source  o_dir
);
    localparam int NL = udv_pkg::LANES;
    localparam int PS = udv_pkg::PIPE_STAGES;
    localparam int US = udv_pkg::UNIT_STAGES;

    logic                                        w_en;
    logic signed [udv_pkg::COMPONENT_BITS-1:0]  w_start [NL];
    logic signed [udv_pkg::COMPONENT_BITS-1:0]  w_end   [NL];
    logic [udv_pkg::SQ_BITS-1:0]                 w_sq    [NL];
    logic                                        w_neg   [NL];
    logic signed [udv_pkg::UNIT_BITS-1:0]        w_unit  [NL];
    logic [udv_pkg::LEN_BITS-1:0]                w_len;

    logic [udv_pkg::SUM_BITS-1:0] n_sum;
    logic [udv_pkg::SUM_BITS-1:0] r_sum;
    logic [udv_pkg::SQ_BITS-1:0]  r_sq  [NL];
    logic                         r_neg [NL];
    logic [PS-1:0]                r_v;
    logic [US:0]                  r_zero;

    udv_pkg::t_result w_last;
    udv_pkg::t_result r_out;
    udv_pkg::t_result r_skid;
    logic             r_out_v;
    logic             r_skid_v;
    logic             w_take;

    assign w_en   = !r_skid_v;
    assign w_take = r_out_v && o_dir.ready;

    assign w_start[0] = i_pt.start_x;
    assign w_start[1] = i_pt.start_y;
    assign w_start[2] = i_pt.start_z;
    assign w_end[0]   = i_pt.end_x;
    assign w_end[1]   = i_pt.end_y;
    assign w_end[2]   = i_pt.end_z;

    for (genvar l = 0; l < NL; l++) begin : g_lane
        udv_square u_square (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_start(w_start[l]),
            .i_end  (w_end[l]),
            .o_sq   (w_sq[l]),
            .o_neg  (w_neg[l])
        );

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq[l]  <= w_sq[l];
                r_neg[l] <= w_neg[l];
            end
        end

        udv_unit u_unit (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_sq  (r_sq[l]),
            .i_sum (r_sum),
            .i_neg (r_neg[l]),
            .o_unit(w_unit[l])
        );
    end

    assign n_sum = {2'b00, w_sq[0]} + {2'b00, w_sq[1]} + {2'b00, w_sq[2]};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum  <= n_sum;
            r_zero <= {r_zero[US-1:0], n_sum == '0};
        end
    end

    udv_length u_length (
        .i_clk(i_clk),
        .i_en (w_en),
        .i_sum(r_sum),
        .o_len(w_len)
    );

    always_comb begin
        w_last.zero_length = r_zero[US];
        w_last.unit_x      = r_zero[US] ? '0 : w_unit[0];
        w_last.unit_y      = r_zero[US] ? '0 : w_unit[1];
        w_last.unit_z      = r_zero[US] ? '0 : w_unit[2];
        w_last.magnitude   = r_zero[US] ? '0 : w_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= '0;
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_en) begin
                r_v <= {r_v[PS-2:0], i_pt.valid};
            end
            if (r_skid_v) begin
                if (w_take) begin
                    r_out    <= r_skid;
                    r_skid_v <= 1'b0;
                end
            end else if (r_v[PS-1]) begin
                if (!r_out_v || w_take) begin
                    r_out   <= w_last;
                    r_out_v <= 1'b1;
                end else begin
                    r_skid   <= w_last;
                    r_skid_v <= 1'b1;
                end
            end else if (w_take) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign i_pt.ready        = !r_skid_v;
    assign o_dir.valid       = r_out_v;
    assign o_dir.unit_x      = r_out.unit_x;
    assign o_dir.unit_y      = r_out.unit_y;
    assign o_dir.unit_z      = r_out.unit_z;
    assign o_dir.magnitude   = r_out.magnitude;
    assign o_dir.zero_length = r_out.zero_length;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("Skid register holds a result while the output register is empty.");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_skid_v && r_v[PS-1] && r_out_v && !o_dir.ready) |=> r_skid_v)
        else $error("A finished result was not caught by the skid register.");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.zero_length) |->
            (r_out.unit_x == '0 && r_out.unit_y == '0 && r_out.unit_z == '0
             && r_out.magnitude == '0))
        else $error("Zero-length result carries nonzero fields.");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out.zero_length) |->
            (r_out.unit_x <= $signed(32'sh4000_0000) && r_out.unit_x >= $signed(-32'sh4000_0000)
             && r_out.magnitude != '0))
        else $error("Unit component out of range or length zero for a nonzero vector.");
endmodule

/* sv/udv_square.sv */
// Lane front end: exact difference of one component, its magnitude and sign, then its square.
// Two register stages under a shared enable. Depends on udv_pkg.
module udv_square (
    input  logic                                       i_clk,
    input  logic                                       i_en,
    input  logic signed [udv_pkg::COMPONENT_BITS-1:0] i_start,
    input  logic signed [udv_pkg::COMPONENT_BITS-1:0] i_end,
    output logic [udv_pkg::SQ_BITS-1:0]                o_sq,
    output logic                                       o_neg
);
    logic signed [udv_pkg::DIFF_BITS-1:0] w_diff;
    logic [udv_pkg::DIFF_BITS-1:0]        w_neg_diff;
    logic [udv_pkg::ABS_BITS-1:0]         n_abs;
    logic [udv_pkg::ABS_BITS-1:0]         r_abs;
    logic                                 r_neg1;
    logic [udv_pkg::SQ_BITS-1:0]          r_sq;
    logic                                 r_neg2;

    always_comb begin
        w_diff     = {i_end[udv_pkg::COMPONENT_BITS-1], i_end}
                   - {i_start[udv_pkg::COMPONENT_BITS-1], i_start};
        w_neg_diff = -w_diff;
        n_abs      = w_diff[udv_pkg::DIFF_BITS-1] ? w_neg_diff[udv_pkg::ABS_BITS-1:0]
                                                   : w_diff[udv_pkg::ABS_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_abs  <= n_abs;
            r_neg1 <= w_diff[udv_pkg::DIFF_BITS-1];
            r_sq   <= {{udv_pkg::ABS_BITS{1'b0}}, r_abs} * {{udv_pkg::ABS_BITS{1'b0}}, r_abs};
            r_neg2 <= r_neg1;
        end
    end

    assign o_sq  = r_sq;
    assign o_neg = r_neg2;
endmodule

/* sv/udv_unit.sv */
// Lane back end: quotient of the squared component times 2^(2F) by the squared length,
// one bit per stage, then its integer square root, one bit per stage. Depends on udv_pkg.
module udv_unit (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [udv_pkg::SQ_BITS-1:0]           i_sq,
    input  logic [udv_pkg::SUM_BITS-1:0]          i_sum,
    input  logic                                  i_neg,
    output logic signed [udv_pkg::UNIT_BITS-1:0] o_unit
);
    localparam int QB = udv_pkg::QUO_BITS;
    localparam int RB = udv_pkg::ROOT_BITS;
    localparam int SB = udv_pkg::SUM_BITS;
    localparam int RR = udv_pkg::ROOT_REM_BITS;
    localparam int QP = udv_pkg::QPAD_BITS;

    logic [SB-1:0] r_rem [QB];
    logic [SB-1:0] r_div [QB];
    logic [QB-1:0] r_quo [QB];
    logic          r_dneg [QB];

    logic [RR-1:0] r_rrem  [RB];
    logic [RB-1:0] r_root  [RB];
    logic [QP-1:0] r_y     [RB];
    logic          r_rneg  [RB];

    logic [udv_pkg::UNIT_BITS-1:0] w_mag;

    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [SB-1:0] w_src_rem;
        logic [SB-1:0] w_src_div;
        logic [QB-1:0] w_src_quo;
        logic          w_src_neg;
        logic          w_bit;
        logic [SB:0]   w_trial;
        logic [SB:0]   w_diff;
        logic          w_ge;
        if (k == 0) begin : g_first
            assign w_src_rem = {2'b00, i_sq[udv_pkg::SQ_BITS-1:1]};
            assign w_src_div = i_sum;
            assign w_src_quo = '0;
            assign w_src_neg = i_neg;
            assign w_bit     = i_sq[0];
        end else begin : g_next
            assign w_src_rem = r_rem[k-1];
            assign w_src_div = r_div[k-1];
            assign w_src_quo = r_quo[k-1];
            assign w_src_neg = r_dneg[k-1];
            assign w_bit     = 1'b0;
        end
        assign w_trial = {w_src_rem, w_bit};
        assign w_diff  = w_trial - {1'b0, w_src_div};
        assign w_ge    = w_trial >= {1'b0, w_src_div};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_diff[SB-1:0] : w_trial[SB-1:0];
                r_div[k]  <= w_src_div;
                r_quo[k]  <= {w_src_quo[QB-2:0], w_ge};
                r_dneg[k] <= w_src_neg;
            end
        end
    end

    for (genvar j = 0; j < RB; j++) begin : g_root
        logic [RR-1:0] w_src_rem;
        logic [RB-1:0] w_src_root;
        logic [QP-1:0] w_src_y;
        logic          w_src_neg;
        logic [RR+1:0] w_trem;
        logic [RR+1:0] w_trial;
        logic [RR+1:0] w_diff;
        logic          w_ge;
        if (j == 0) begin : g_first
            assign w_src_rem  = '0;
            assign w_src_root = '0;
            assign w_src_y    = {1'b0, r_quo[QB-1]};
            assign w_src_neg  = r_dneg[QB-1];
        end else begin : g_next
            assign w_src_rem  = r_rrem[j-1];
            assign w_src_root = r_root[j-1];
            assign w_src_y    = r_y[j-1];
            assign w_src_neg  = r_rneg[j-1];
        end
        assign w_trem  = {w_src_rem, w_src_y[QP-1:QP-2]};
        assign w_trial = {{(RR-RB){1'b0}}, w_src_root, 2'b01};
        assign w_diff  = w_trem - w_trial;
        assign w_ge    = w_trem >= w_trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rrem[j] <= w_ge ? w_diff[RR-1:0] : w_trem[RR-1:0];
                r_root[j] <= {w_src_root[RB-2:0], w_ge};
                r_y[j]    <= {w_src_y[QP-3:0], 2'b00};
                r_rneg[j] <= w_src_neg;
            end
        end
    end

    assign w_mag  = {1'b0, r_root[RB-1]};
    assign o_unit = r_rneg[RB-1] ? -w_mag : w_mag;
endmodule

/* sv/udv_length.sv */
// Length unit: integer square root of the sum of squares, one result bit per stage,
// followed by a delay line that lines it up with the lanes. Depends on udv_pkg.
module udv_length (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [udv_pkg::SUM_BITS-1:0]  i_sum,
    output logic [udv_pkg::LEN_BITS-1:0]  o_len
);
    localparam int LB = udv_pkg::LEN_BITS;
    localparam int LR = udv_pkg::LEN_REM_BITS;
    localparam int SB = udv_pkg::SUM_BITS;
    localparam int DL = udv_pkg::LEN_DELAY;

    logic [LR-1:0] r_rem  [LB];
    logic [LB-1:0] r_root [LB];
    logic [SB-1:0] r_s    [LB];
    logic [LB-1:0] r_dly  [DL];

    for (genvar j = 0; j < LB; j++) begin : g_root
        logic [LR-1:0] w_src_rem;
        logic [LB-1:0] w_src_root;
        logic [SB-1:0] w_src_s;
        logic [LR+1:0] w_trem;
        logic [LR+1:0] w_trial;
        logic [LR+1:0] w_diff;
        logic          w_ge;
        if (j == 0) begin : g_first
            assign w_src_rem  = '0;
            assign w_src_root = '0;
            assign w_src_s    = i_sum;
        end else begin : g_next
            assign w_src_rem  = r_rem[j-1];
            assign w_src_root = r_root[j-1];
            assign w_src_s    = r_s[j-1];
        end
        assign w_trem  = {w_src_rem, w_src_s[SB-1:SB-2]};
        assign w_trial = {{(LR-LB){1'b0}}, w_src_root, 2'b01};
        assign w_diff  = w_trem - w_trial;
        assign w_ge    = w_trem >= w_trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= w_ge ? w_diff[LR-1:0] : w_trem[LR-1:0];
                r_root[j] <= {w_src_root[LB-2:0], w_ge};
                r_s[j]    <= {w_src_s[SB-3:0], 2'b00};
            end
        end
    end

    for (genvar d = 0; d < DL; d++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dly[d] <= (d == 0) ? r_root[LB-1] : r_dly[(d == 0) ? 0 : d-1];
            end
        end
    end

    assign o_len = r_dly[DL-1];
endmodule
